// ===== src/csv_rfs_pkg.sv =====
// Shared types and constants for the CSV record/field splitter.
// No dependencies; imported by csv_record_field_splitter_top.
package csv_rfs_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int RES_DEPTH       = 2;

	localparam logic [7:0] BYTE_LF        = 8'h0A;
	localparam logic [7:0] BYTE_CR        = 8'h0D;
	localparam logic [7:0] DELIM_RST      = 8'd44;
	localparam logic [7:0] QUOTE_RST      = 8'd34;

	// configuration register indexes
	localparam logic REG_DELIM = 1'b0;
	localparam logic REG_QUOTE = 1'b1;

	typedef enum logic [5:0] {
		MODE_START  = 6'b000001,
		MODE_PLAIN  = 6'b000010,
		MODE_QUOTED = 6'b000100,
		MODE_AFTERQ = 6'b001000,
		MODE_CR     = 6'b010000,
		MODE_SKIP   = 6'b100000
	} mode_t;

	// where a reported field's content ends
	typedef enum logic [1:0] {
		END_AT_POS  = 2'd0,
		END_AT_NEXT = 2'd1,
		END_AT_PREV = 2'd2
	} endp_t;

	typedef struct packed {
		logic        is_field;
		logic [31:0] field_offset;
		logic [31:0] field_length;
		logic        was_quoted;
		logic        unquote_needed;
		logic        ends_record;
		logic        last_of_item;
	} res_t;

endpackage

// ===== src/csv_record_field_splitter_top.sv =====
// CSV record/field splitter, top level: input register, tokenizer logic, result register.
// Depends on csv_rfs_pkg.
//
// Byte-serial CSV tokenizer. One buffer byte is taken per transfer on the input
// channel (is_final marks the last byte of a buffer); each field found is reported
// as an offset and length into the buffer, with quoted / unquote-needed / record-end
// flags, and last_of_item marks the last result a byte caused. A byte gives zero,
// one or two results. Throughput is one byte per cycle while the output side takes
// each result; a byte that yields two results holds the input until both have left
// the result register, since the output side moves one result per transfer. A byte
// passes the input register, then the result register. Position counters are
// OFFSET_BITS wide and wrap; offsets and lengths are cut to 32 bits on the ports.
// Delimiter and quote bytes are written on the cfg port (index 0 and 1); the user must
// write them only while idle (not enforced by the block); the cfg port is always ready.
module csv_record_field_splitter_top #(
	parameter int OFFSET_BITS = csv_rfs_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        is_final,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_field,
	output logic [31:0] field_offset,
	output logic [31:0] field_length,
	output logic        was_quoted,
	output logic        unquote_needed,
	output logic        ends_record,
	output logic        last_of_item
);
	import csv_rfs_pkg::*;

	localparam int OW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

	// config registers
	logic [7:0] delim_q, quote_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// tokenizer state
	logic [OFFSET_BITS-1:0] pos_q, start_q;
	mode_t                  mode_q;
	logic                   dq_q, fq_q;

	// result register, two entries, entry 0 is presented
	res_t       res_q [RES_DEPTH];
	logic [1:0] cnt_q;

	logic       pop, proc;
	logic [1:0] cnt_left;

	// next-state and result build
	logic [OFFSET_BITS-1:0] pos_next, pos_prev, st_d, fs, endp, flen;
	mode_t                  mode_d;
	logic                   dq_d, fq_d, f_q, f_dq;
	logic                   is_delim, is_quote, is_cr, is_lf;
	logic                   do_begin, do_term, r0_en, r0_isf, r0_ends, r1_en, r1_isf;
	endp_t                  endp_sel;
	logic [1:0]             nres;
	logic [OW-1:0]          off_w, len_w, nxt_w;
	res_t                   r0, r1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RST;
			quote_q <= QUOTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELIM: delim_q <= cfg_data;
				REG_QUOTE: quote_q <= cfg_data;
				default:   delim_q <= delim_q;
			endcase
		end
	end

	// handshake: a byte is worked on only when the result register will be empty
	assign pop      = out_valid && out_ready;
	assign cnt_left = cnt_q - {1'b0, pop};
	assign proc     = valid_s1 && (cnt_left == 2'd0);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			fin_s1  <= is_final;
		end
	end

	// byte classes; delimiter beats CR/LF, quote is tested first at field start
	assign is_delim = (byte_s1 == delim_q);
	assign is_quote = (byte_s1 == quote_q);
	assign is_cr    = (byte_s1 == BYTE_CR);
	assign is_lf    = (byte_s1 == BYTE_LF);
	assign pos_next = pos_q + OFFSET_BITS'(1);
	assign pos_prev = pos_q - OFFSET_BITS'(1);

	always_comb begin
		st_d     = start_q;
		mode_d   = mode_q;
		dq_d     = dq_q;
		fq_d     = fq_q;
		fs       = start_q;
		f_q      = fq_q;
		f_dq     = dq_q;
		do_begin = 1'b0;
		do_term  = 1'b0;
		endp_sel = END_AT_POS;
		r0_en    = 1'b0;
		r0_isf   = 1'b1;
		r0_ends  = 1'b0;
		r1_en    = 1'b0;
		r1_isf   = 1'b0;

		unique case (mode_q)
			MODE_PLAIN: begin
				if (is_delim || is_cr || is_lf) begin
					do_term = 1'b1;
				end else if (fin_s1) begin
					r0_en    = 1'b1;
					r0_ends  = 1'b1;
					endp_sel = END_AT_NEXT;
				end
			end
			MODE_QUOTED: begin
				if (is_quote) begin
					if (fin_s1) begin
						r0_en   = 1'b1;
						r0_ends = 1'b1;
					end else begin
						mode_d = MODE_AFTERQ;
					end
				end else if (fin_s1) begin
					r0_en    = 1'b1;
					r0_ends  = 1'b1;
					endp_sel = END_AT_NEXT;
				end
			end
			MODE_AFTERQ: begin
				if (is_quote) begin
					dq_d   = 1'b1;
					f_dq   = 1'b1;
					mode_d = MODE_QUOTED;
					if (fin_s1) begin
						r0_en    = 1'b1;
						r0_ends  = 1'b1;
						endp_sel = END_AT_NEXT;
					end
				end else begin
					do_term  = 1'b1;
					endp_sel = END_AT_PREV;
				end
			end
			MODE_CR: begin
				if (is_lf) begin
					st_d   = pos_next;
					mode_d = MODE_START;
				end else begin
					do_begin = 1'b1;
				end
			end
			MODE_SKIP: begin
				if (is_lf || fin_s1) begin
					r0_en   = 1'b1;
					r0_isf  = 1'b0;
					r0_ends = 1'b1;
				end
				if (is_lf) begin
					st_d   = pos_next;
					mode_d = MODE_START;
				end
			end
			default: begin
				do_begin = 1'b1;
			end
		endcase

		if (do_begin) begin
			fs   = pos_q;
			st_d = pos_q;
			f_q  = 1'b0;
			f_dq = 1'b0;
			fq_d = 1'b0;
			dq_d = 1'b0;
			if (is_quote) begin
				fs     = pos_next;
				st_d   = pos_next;
				f_q    = 1'b1;
				fq_d   = 1'b1;
				mode_d = MODE_QUOTED;
				if (fin_s1) begin
					r0_en    = 1'b1;
					r0_ends  = 1'b1;
					endp_sel = END_AT_NEXT;
				end
			end else if (is_delim || is_cr || is_lf) begin
				do_term = 1'b1;
			end else begin
				mode_d = MODE_PLAIN;
				if (fin_s1) begin
					r0_en    = 1'b1;
					r0_ends  = 1'b1;
					endp_sel = END_AT_NEXT;
				end
			end
		end

		// the open field ends here
		if (do_term) begin
			r0_en = 1'b1;
			priority if (is_delim) begin
				r0_ends = 1'b0;
				st_d    = pos_next;
				mode_d  = MODE_START;
				r1_en   = fin_s1;
				r1_isf  = 1'b1;
			end else if (is_cr) begin
				r0_ends = 1'b1;
				st_d    = pos_next;
				mode_d  = MODE_CR;
			end else if (is_lf) begin
				r0_ends = 1'b1;
				st_d    = pos_next;
				mode_d  = MODE_START;
			end else begin
				r0_ends = 1'b0;
				mode_d  = MODE_SKIP;
				r1_en   = fin_s1;
				r1_isf  = 1'b0;
			end
		end

		// a reported field clears the per-field flags
		if (r0_en && r0_isf) begin
			fq_d = 1'b0;
			dq_d = 1'b0;
		end

		unique case (endp_sel)
			END_AT_NEXT: endp = pos_next;
			END_AT_PREV: endp = pos_prev;
			default:     endp = pos_q;
		endcase
		flen  = endp - fs;
		off_w = OW'(fs);
		len_w = OW'(flen);
		nxt_w = OW'(pos_next);

		r0.is_field       = r0_isf;
		r0.field_offset   = r0_isf ? off_w[31:0] : 32'd0;
		r0.field_length   = r0_isf ? len_w[31:0] : 32'd0;
		r0.was_quoted     = r0_isf && f_q;
		r0.unquote_needed = r0_isf && f_dq;
		r0.ends_record    = r0_ends;
		r0.last_of_item   = !r1_en;

		// second result: empty last field after a final delimiter, or a record-end marker
		r1.is_field       = r1_isf;
		r1.field_offset   = r1_isf ? nxt_w[31:0] : 32'd0;
		r1.field_length   = 32'd0;
		r1.was_quoted     = 1'b0;
		r1.unquote_needed = 1'b0;
		r1.ends_record    = 1'b1;
		r1.last_of_item   = 1'b1;

		nres = {1'b0, r0_en} + {1'b0, r1_en};
	end

	// tokenizer state; a final byte returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			mode_q  <= MODE_START;
			dq_q    <= 1'b0;
			fq_q    <= 1'b0;
		end else if (proc) begin
			if (fin_s1) begin
				pos_q   <= '0;
				start_q <= '0;
				mode_q  <= MODE_START;
				dq_q    <= 1'b0;
				fq_q    <= 1'b0;
			end else begin
				pos_q   <= pos_next;
				start_q <= st_d;
				mode_q  <= mode_d;
				dq_q    <= dq_d;
				fq_q    <= fq_d;
			end
		end
	end

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (proc) begin
			cnt_q <= nres;
		end else if (pop) begin
			cnt_q <= cnt_left;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q[0] <= r0_en ? r0 : r1;
			res_q[1] <= r1;
		end else if (pop && (cnt_q == 2'd2)) begin
			res_q[0] <= res_q[1];
		end
	end

	assign out_valid      = (cnt_q != 2'd0);
	assign is_field       = res_q[0].is_field;
	assign field_offset   = res_q[0].field_offset;
	assign field_length   = res_q[0].field_length;
	assign was_quoted     = res_q[0].was_quoted;
	assign unquote_needed = res_q[0].unquote_needed;
	assign ends_record    = res_q[0].ends_record;
	assign last_of_item   = res_q[0].last_of_item;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result register overfilled");

	a_first_of_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_item) |-> (cnt_q == 2'd2))
		else $error("non-last result presented without its partner");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_field) |->
		(field_offset == 32'd0 && field_length == 32'd0 && ends_record && !was_quoted))
		else $error("record-end marker carries field data");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && fin_s1) |=> (pos_q == '0 && start_q == '0 && mode_q == MODE_START))
		else $error("state not cleared after final byte");
`endif

endmodule
